// ----- hdl/wis_pkg.sv -----
package wis_pkg;

  localparam int unsigned MAX_ENTRIES = 16;
  localparam int unsigned IDX_W       = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned WEIGHT_W    = 16;
  localparam int unsigned DRAW_W      = 31;
  localparam int unsigned TOT_W       = WEIGHT_W + IDX_W;
  localparam int unsigned SCALE       = 1000;
  localparam int unsigned SPAN        = 999;
  localparam int unsigned SEL_W       = 10;
  localparam int unsigned CUM_W       = 11;
  localparam int unsigned PROD_W      = WEIGHT_W + 10;
  localparam int unsigned DVD_W       = PROD_W;
  localparam int unsigned DVS_W       = TOT_W;
  localparam int unsigned DIV_CW      = $clog2(DVD_W + 1);
  localparam int unsigned OUT_IDX_W   = 4;
  // draw reduction: 2**FOLD_W is congruent to FOLD_MUL modulo SPAN
  localparam int unsigned FOLD_W      = 10;
  localparam int unsigned FOLD_MUL    = (1 << FOLD_W) % SPAN;

endpackage

// ----- hdl/wis_store.sv -----
module wis_store
  import wis_pkg::*;
(
  input  logic                clk_i,
  input  logic                wr_en_i,
  input  logic [IDX_W-1:0]    wr_addr_i,
  input  logic [WEIGHT_W-1:0] wr_data_i,
  input  logic [IDX_W-1:0]    rd_addr_i,
  output logic [WEIGHT_W-1:0] rd_data_o
);

  logic [WEIGHT_W-1:0] mem [MAX_ENTRIES];
  logic [WEIGHT_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- hdl/wis_divider.sv -----
module wis_divider
  import wis_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  logic              busy_q;
  logic              done_q;
  logic [DIV_CW-1:0] cnt_q;
  logic [DVD_W-1:0]  quo_q;
  logic [DVS_W-1:0]  rem_q;
  logic [DVS_W-1:0]  dvs_q;
  logic [DVS_W+1:0]  diff;
  logic              q_bit;
  logic [DVS_W-1:0]  rem_d;

  // restoring step: shift in next dividend bit, subtract when it fits
  assign diff  = {1'b0, rem_q, quo_q[DVD_W-1]} - {2'b00, dvs_q};
  assign q_bit = ~diff[DVS_W+1];
  assign rem_d = q_bit ? diff[DVS_W-1:0] : {rem_q[DVS_W-2:0], quo_q[DVD_W-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CW'(DVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DVD_W-2:0], q_bit};
      rem_q <= rem_d;
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- hdl/weighted_index_selector.sv -----
// Weight words are accepted back to back while the selector is idle.
// The word marked last starts a selection: the draw is folded mod 999, then each
// entry walked takes a memory read, a multiply and a 26-step divide, for at most
// MAX_ENTRIES-1 entries; the last entry needs no divide; a zero total skips the walk.
// The result sits in an output register; the next list can load while it waits.
// Reset (rst_ni low, asynchronous) empties the list and drops any pending result.
module weighted_index_selector
  import wis_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // weight[15:0], draw[46:16], zero pad
  input  logic        s_axis_tlast_i,   // last_entry
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // chosen_index[3:0], zero pad
  output logic        m_axis_tuser_o    // total_zero
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_RD,
    S_MUL,
    S_DIV,
    S_DONE
  } state_e;

  state_e              state_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [TOT_W-1:0]    total_q;
  logic [SEL_W-1:0]    sel_q;
  logic [CUM_W-1:0]    cum_q;
  logic [IDX_W-1:0]    i_q;
  logic [IDX_W-1:0]    res_q;
  logic                zero_q;
  logic                out_valid_q;
  logic [OUT_IDX_W-1:0] out_idx_q;
  logic                out_zero_q;
  logic [DRAW_W-1:0]   mod_q;

  logic [WEIGHT_W-1:0] in_weight;
  logic [DRAW_W-1:0]   in_draw;
  logic                accept;
  logic                room;
  logic [TOT_W-1:0]    total_d;
  logic [CNT_W-1:0]    cnt_d;
  logic                mem_we;
  logic [WEIGHT_W-1:0] rd_data;
  logic [PROD_W-1:0]   prod;
  logic                dv_start;
  logic [DVD_W-1:0]    dv_dividend;
  logic [DVS_W-1:0]    dv_divisor;
  logic                dv_busy;
  logic                dv_done;
  logic [DVD_W-1:0]    dv_quo;
  logic [CUM_W-1:0]    cum_d;
  logic                walk_end;
  logic [31:0]         res_ext;
  logic [DRAW_W-1:0]   mod_hi;
  logic [DRAW_W-1:0]   fold_d;
  logic                mod_small;
  logic [SEL_W-1:0]    mod_low;
  logic [SEL_W-1:0]    sel_d;
  logic                out_load;

  assign in_weight = s_axis_tdata_i[15:0];
  assign in_draw   = s_axis_tdata_i[46:16];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign room            = (cnt_q < CNT_W'(MAX_ENTRIES));
  assign mem_we          = accept && room;
  assign total_d         = room ? total_q + TOT_W'(in_weight) : total_q;
  assign cnt_d           = room ? cnt_q + 1'b1 : cnt_q;

  wis_store u_store (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (cnt_q[IDX_W-1:0]),
    .wr_data_i (in_weight),
    .rd_addr_i (i_q),
    .rd_data_o (rd_data)
  );

  // draw mod SPAN: fold the bits above FOLD_W down until the value fits,
  // then one compare and subtract, and one is added (range 1..SPAN)
  assign mod_hi    = DRAW_W'(mod_q[DRAW_W-1:FOLD_W]);
  assign fold_d    = mod_hi * DRAW_W'(FOLD_MUL) + DRAW_W'(mod_q[FOLD_W-1:0]);
  assign mod_small = (mod_q[DRAW_W-1:FOLD_W] == '0);
  assign mod_low   = SEL_W'(mod_q[FOLD_W-1:0]);
  assign sel_d     = (mod_low >= SEL_W'(SPAN)) ? mod_low - SEL_W'(SPAN) + 1'b1
                                               : mod_low + 1'b1;

  assign prod = PROD_W'(rd_data) * PROD_W'(SCALE);

  // divider: weight*SCALE / total per entry
  assign dv_start    = (state_q == S_MUL);
  assign dv_dividend = DVD_W'(prod);
  assign dv_divisor  = total_q;

  wis_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (dv_start),
    .dividend_i (dv_dividend),
    .divisor_i  (dv_divisor),
    .busy_o     (dv_busy),
    .done_o     (dv_done),
    .quotient_o (dv_quo)
  );

  assign cum_d    = cum_q + dv_quo[CUM_W-1:0];
  assign walk_end = (CNT_W'(i_q) + 1'b1) >= cnt_q;
  assign out_load = (state_q == S_DONE) && (!out_valid_q || m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      total_q     <= '0;
      sel_q       <= '0;
      cum_q       <= '0;
      i_q         <= '0;
      res_q       <= '0;
      zero_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_idx_q   <= '0;
      out_zero_q  <= 1'b0;
      mod_q       <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            cnt_q   <= cnt_d;
            total_q <= total_d;
            if (s_axis_tlast_i) begin
              res_q <= '0;
              i_q   <= '0;
              cum_q <= '0;
              mod_q <= in_draw;
              if (total_d == '0) begin
                zero_q  <= 1'b1;
                state_q <= S_DONE;
              end else begin
                zero_q  <= 1'b0;
                state_q <= S_MOD;
              end
            end
          end
        end
        S_MOD: begin
          if (mod_small) begin
            sel_q   <= sel_d;
            state_q <= S_RD;
          end else begin
            mod_q <= fold_d;
          end
        end
        S_RD: begin
          if (walk_end) begin
            res_q   <= IDX_W'(cnt_q - 1'b1);
            state_q <= S_DONE;
          end else begin
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (dv_done) begin
            cum_q <= cum_d;
            if (cum_d >= CUM_W'(sel_q)) begin
              res_q   <= i_q;
              state_q <= S_DONE;
            end else begin
              i_q     <= i_q + 1'b1;
              state_q <= S_RD;
            end
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_idx_q  <= res_ext[OUT_IDX_W-1:0];
            out_zero_q <= zero_q;
            cnt_q      <= '0;
            total_q    <= '0;
            state_q    <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign res_ext = 32'(res_q);

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, out_idx_q};
  assign m_axis_tuser_o  = out_zero_q;

`ifndef SYNTHESIS
  a_div_idle_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_start |-> !dv_busy)
    else $error("divider started while busy");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_ENTRIES))
    else $error("entry count beyond capacity");

  a_zero_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o[3:0] == 4'd0))
    else $error("zero total with nonzero index");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |=> (state_q == S_DIV) && dv_busy)
    else $error("divide not running after start");
`endif

endmodule
